// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the top-level rtl file of the lcd refresh block
// expects clk and rst_n in scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: invariant");
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// consequent holds in the cycle after the antecedent
`define ASSERT_IMPLY_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_IMPLY_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/clro_pkg.sv =====
// types, constants and codes of the lcd refresh and overlay block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package clro_pkg;

  // display geometry
  localparam int CHARS_PER_LINE = 16;
  localparam int LINE_COUNT     = 2;
  localparam int CELL_COUNT     = LINE_COUNT * CHARS_PER_LINE;
  localparam int CELL_W         = $clog2(CELL_COUNT);
  localparam int IDX_W          = $clog2(CHARS_PER_LINE);

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // lcd commands and limits
  localparam logic [7:0]  CMD_LINE1      = 8'h80;
  localparam logic [7:0]  CMD_LINE2      = 8'hC0;
  localparam logic [7:0]  PACE_MAX       = 8'hFF;
  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;
  localparam logic [7:0]  PACE_GAP_RESET = 8'd2;
  localparam logic [7:0]  TPS_RESET      = 8'd12;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_WR_MAIN = 2'd1,
    ACT_WR_OVL  = 2'd2,
    ACT_RD_MAIN = 2'd3
  } action_t;

  typedef enum logic {
    REG_PACE_GAP  = 1'b0,
    REG_TICKS_SEC = 1'b1
  } cfg_reg_t;

  // refresh sequencer, one-hot
  typedef enum logic [8:0] {
    S_CMD1     = 9'b000000001,
    S_GAP_CMD1 = 9'b000000010,
    S_DATA1    = 9'b000000100,
    S_GAP_D1   = 9'b000001000,
    S_GAP_END1 = 9'b000010000,
    S_CMD2     = 9'b000100000,
    S_GAP_CMD2 = 9'b001000000,
    S_DATA2    = 9'b010000000,
    S_GAP_D2   = 9'b100000000
  } seq_state_t;

  typedef struct packed {
    logic [1:0] action;
    logic       line_select;
    logic [3:0] column;
    logic [7:0] char_code;
    logic [7:0] timeout_seconds;
  } in_item_t;

  typedef struct packed {
    logic       is_read;
    logic       reg_select;
    logic [3:0] bus_nibble;
    logic       last_nibble;
    logic       frame_done;
    logic [7:0] read_data;
  } out_item_t;

  // classified request as held in the queue
  typedef struct packed {
    action_t           action;
    logic              col_ok;
    logic [CELL_W-1:0] addr;
    logic [7:0]        char_code;
    logic [7:0]        window;
  } cmd_t;

  // what the result stage has to emit
  typedef struct packed {
    logic       is_read;
    logic       reg_select;
    logic       from_mem;
    logic       from_ovl;
    logic       zero;
    logic [7:0] const_byte;
    logic       frame_done;
  } res_desc_t;

endpackage

// ===== rtl/core/clro_front.sv =====
// front end: takes input requests, classifies them and works out the overlay window
// depends on clro_pkg
`timescale 1ns / 1ps

module clro_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  clro_pkg::in_item_t in_data,
  input  logic [7:0]         ticks_per_sec,
  input  logic               q_full,
  output logic               push_valid,
  output clro_pkg::cmd_t     push_cmd
);

  logic           f_vld_r;
  clro_pkg::cmd_t f_cmd_r;
  clro_pkg::cmd_t cls;
  logic [15:0]    win_prod;
  logic           line_eff;
  logic           load;

  // stall only when the held request cannot move on
  assign in_stall   = f_vld_r && q_full;
  assign load       = in_valid && !in_stall;
  assign push_valid = f_vld_r;
  assign push_cmd   = f_cmd_r;

  // classification and window product
  always_comb begin
    win_prod      = {8'd0, in_data.timeout_seconds} * {8'd0, ticks_per_sec};
    cls.action    = clro_pkg::action_t'(in_data.action);
    line_eff      = (cls.action == clro_pkg::ACT_RD_MAIN) ? 1'b1 : in_data.line_select;
    cls.col_ok    = int'(in_data.column) < clro_pkg::CHARS_PER_LINE;
    cls.addr      = clro_pkg::CELL_W'(int'(in_data.column) +
                    (line_eff ? clro_pkg::CHARS_PER_LINE : 0));
    cls.char_code = in_data.char_code;
    cls.window    = win_prod[7:0];
  end

  // valid flag of the holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (load) begin
      f_vld_r <= 1'b1;
    end else if (!q_full) begin
      f_vld_r <= 1'b0;
    end
  end

  // payload of the holding register
  always_ff @(posedge clk) begin
    if (load) begin
      f_cmd_r <= cls;
    end
  end

endmodule

// ===== rtl/core/clro_queue.sv =====
// short request queue between the front end and the sequencer
// depends on clro_pkg
`timescale 1ns / 1ps

module clro_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  clro_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_vld,
  output clro_pkg::cmd_t head_cmd
);

  clro_pkg::cmd_t                  slot_r [clro_pkg::QUEUE_DEPTH];
  logic [clro_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [clro_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [clro_pkg::QCNT_W-1:0]     cnt_r;
  logic                            push;

  assign full     = cnt_r == clro_pkg::QCNT_W'(clro_pkg::QUEUE_DEPTH);
  assign head_vld = cnt_r != '0;
  assign head_cmd = slot_r[rd_ptr_r];
  assign push     = push_valid && !full;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == clro_pkg::QPTR_W'(clro_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + clro_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == clro_pkg::QPTR_W'(clro_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + clro_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + clro_pkg::QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - clro_pkg::QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/clro_back.sv =====
// back end: refresh sequencer, frame buffers and nibble result stage
// depends on clro_pkg
`timescale 1ns / 1ps

module clro_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           pace_gap,
  input  logic                 head_vld,
  input  clro_pkg::cmd_t       head_cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output clro_pkg::out_item_t  out_data,
  output clro_pkg::seq_state_t seq_state
);

  // sequencer and overlay state
  clro_pkg::seq_state_t          seq_r, seq_nxt;
  logic [clro_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [7:0]                    pace_r, pace_nxt;
  logic [15:0]                   elapsed_r, elapsed_nxt;
  logic [7:0]                    window_r, window_nxt;

  // frame buffers with per-position written flags
  logic [7:0]                    main_mem [clro_pkg::CELL_COUNT];
  logic [7:0]                    ovl_mem  [clro_pkg::CELL_COUNT];
  logic [clro_pkg::CELL_COUNT-1:0] main_ok_r;
  logic [clro_pkg::CELL_COUNT-1:0] ovl_ok_r;

  // result stage
  logic                          b_vld_r;
  logic                          phase_r;
  clro_pkg::res_desc_t           desc_r;
  logic [7:0]                    main_rd_r;
  logic [7:0]                    ovl_rd_r;
  logic                          main_rd_ok_r;
  logic                          ovl_rd_ok_r;

  // combinational step
  clro_pkg::res_desc_t           desc;
  logic                          produces;
  logic [clro_pkg::CELL_W-1:0]   rd_cell;
  logic                          wr_main;
  logic                          wr_ovl;
  logic [7:0]                    pace_inc;
  logic [15:0]                   elapsed_inc;
  logic                          show_ovl;
  logic                          idx_last;
  logic                          b_take;
  logic                          b_free;
  logic                          load_b;
  logic [7:0]                    mem_byte;
  logic [7:0]                    res_byte;

  assign seq_state = seq_r;

  // result stage frees up after its final item leaves
  assign b_take = b_vld_r && !out_stall;
  assign b_free = !b_vld_r || (b_take && (desc_r.is_read || phase_r));
  assign pop    = head_vld && (b_free || !produces);
  assign load_b = pop && produces;

  // one request: sequencer step, buffer write or read
  always_comb begin
    seq_nxt     = seq_r;
    idx_nxt     = idx_r;
    pace_nxt    = pace_r;
    elapsed_nxt = elapsed_r;
    window_nxt  = window_r;
    produces    = 1'b0;
    rd_cell     = head_cmd.addr;
    wr_main     = 1'b0;
    wr_ovl      = 1'b0;
    desc        = '0;
    pace_inc    = (pace_r == clro_pkg::PACE_MAX) ? pace_r : pace_r + 8'd1;
    elapsed_inc = (elapsed_r == clro_pkg::ELAPSED_MAX) ? elapsed_r : elapsed_r + 16'd1;
    show_ovl    = (window_r != 8'd0) && (elapsed_inc < {8'd0, window_r});
    idx_last    = int'(idx_r) == clro_pkg::CHARS_PER_LINE - 1;
    case (head_cmd.action)
      clro_pkg::ACT_TICK: begin
        pace_nxt    = pace_inc;
        elapsed_nxt = elapsed_inc;
        if (window_r != 8'd0 && !show_ovl) begin
          window_nxt = 8'd0;
        end
        unique case (seq_r)
          clro_pkg::S_CMD1: begin
            seq_nxt          = clro_pkg::S_GAP_CMD1;
            pace_nxt         = 8'd0;
            produces         = 1'b1;
            desc.const_byte  = clro_pkg::CMD_LINE1;
          end
          clro_pkg::S_GAP_CMD1: begin
            if (pace_inc >= pace_gap) seq_nxt = clro_pkg::S_DATA1;
          end
          clro_pkg::S_DATA1: begin
            produces        = 1'b1;
            pace_nxt        = 8'd0;
            rd_cell         = clro_pkg::CELL_W'(int'(idx_r));
            desc.reg_select = 1'b1;
            desc.from_mem   = 1'b1;
            desc.from_ovl   = show_ovl;
            if (idx_last) begin
              idx_nxt = '0;
              seq_nxt = clro_pkg::S_GAP_END1;
            end else begin
              idx_nxt = idx_r + clro_pkg::IDX_W'(1);
              seq_nxt = clro_pkg::S_GAP_D1;
            end
          end
          clro_pkg::S_GAP_D1: begin
            if (pace_inc >= pace_gap) seq_nxt = clro_pkg::S_DATA1;
          end
          clro_pkg::S_GAP_END1: begin
            if (pace_inc >= pace_gap) seq_nxt = clro_pkg::S_CMD2;
          end
          clro_pkg::S_CMD2: begin
            seq_nxt          = clro_pkg::S_GAP_CMD2;
            pace_nxt         = 8'd0;
            produces         = 1'b1;
            desc.const_byte  = clro_pkg::CMD_LINE2;
          end
          clro_pkg::S_GAP_CMD2: begin
            if (pace_inc >= pace_gap) seq_nxt = clro_pkg::S_DATA2;
          end
          clro_pkg::S_DATA2: begin
            produces        = 1'b1;
            pace_nxt        = 8'd0;
            rd_cell         = clro_pkg::CELL_W'(int'(idx_r) + clro_pkg::CHARS_PER_LINE);
            desc.reg_select = 1'b1;
            desc.from_mem   = 1'b1;
            desc.from_ovl   = show_ovl;
            if (idx_last) begin
              idx_nxt         = '0;
              seq_nxt         = clro_pkg::S_CMD1;
              desc.frame_done = 1'b1;
            end else begin
              idx_nxt = idx_r + clro_pkg::IDX_W'(1);
              seq_nxt = clro_pkg::S_GAP_D2;
            end
          end
          clro_pkg::S_GAP_D2: begin
            if (pace_inc >= pace_gap) seq_nxt = clro_pkg::S_DATA2;
          end
          default: begin
            seq_nxt = clro_pkg::S_CMD1;
          end
        endcase
      end
      clro_pkg::ACT_WR_MAIN: begin
        wr_main = head_cmd.col_ok;
      end
      clro_pkg::ACT_WR_OVL: begin
        window_nxt  = head_cmd.window;
        elapsed_nxt = 16'd0;
        wr_ovl      = head_cmd.col_ok;
      end
      default: begin
        produces      = 1'b1;
        desc.is_read  = 1'b1;
        desc.from_mem = 1'b1;
        desc.zero     = !head_cmd.col_ok;
      end
    endcase
  end

  // sequencer and overlay registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= clro_pkg::S_CMD1;
      idx_r     <= '0;
      pace_r    <= 8'd0;
      elapsed_r <= 16'd0;
      window_r  <= 8'd0;
    end else if (pop) begin
      seq_r     <= seq_nxt;
      idx_r     <= idx_nxt;
      pace_r    <= pace_nxt;
      elapsed_r <= elapsed_nxt;
      window_r  <= window_nxt;
    end
  end

  // written flags, cleared at reset so unwritten positions read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_ok_r    <= '0;
      ovl_ok_r     <= '0;
      main_rd_ok_r <= 1'b0;
      ovl_rd_ok_r  <= 1'b0;
    end else begin
      if (pop && wr_main) main_ok_r[head_cmd.addr] <= 1'b1;
      if (pop && wr_ovl)  ovl_ok_r[head_cmd.addr]  <= 1'b1;
      if (load_b) begin
        main_rd_ok_r <= main_ok_r[rd_cell];
        ovl_rd_ok_r  <= ovl_ok_r[rd_cell];
      end
    end
  end

  // buffer memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (pop && wr_main) main_mem[head_cmd.addr] <= head_cmd.char_code;
    if (pop && wr_ovl)  ovl_mem[head_cmd.addr]  <= head_cmd.char_code;
    if (load_b) begin
      main_rd_r <= main_mem[rd_cell];
      ovl_rd_r  <= ovl_mem[rd_cell];
    end
  end

  // result stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (load_b) begin
      b_vld_r <= 1'b1;
      phase_r <= 1'b0;
    end else if (b_take && (desc_r.is_read || phase_r)) begin
      b_vld_r <= 1'b0;
    end else if (b_take) begin
      phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      desc_r <= desc;
    end
  end

  // result formatting: high nibble, then low nibble, or one read item
  always_comb begin
    mem_byte = desc_r.from_ovl ? (ovl_rd_ok_r ? ovl_rd_r : 8'd0) :
                                 (main_rd_ok_r ? main_rd_r : 8'd0);
    res_byte = desc_r.zero ? 8'd0 : (desc_r.from_mem ? mem_byte : desc_r.const_byte);
    out_data = '0;
    out_data.is_read = desc_r.is_read;
    if (desc_r.is_read) begin
      out_data.read_data = res_byte;
    end else begin
      out_data.reg_select  = desc_r.reg_select;
      out_data.bus_nibble  = phase_r ? res_byte[3:0] : res_byte[7:4];
      out_data.last_nibble = phase_r;
      out_data.frame_done  = phase_r && desc_r.frame_done;
    end
  end

  assign out_valid = b_vld_r;

endmodule

// ===== rtl/core/char_lcd_refresh_overlay_top.sv =====
// top level of the lcd background refresh block with overlay buffer
// depends on clro_pkg, clro_front, clro_queue, clro_back and assert_macros.svh
//
//   port group  | direction | handshake           | carries
//   in_*        | input     | in_valid / in_stall | one request (tick, write, read)
//   out_*       | output    | out_valid/out_stall | one bus nibble or read item
//   cfg_*       | input     | cfg_we              | pace gap / ticks per second
//
// accepts one request per cycle while in_stall is low; a request goes through the front
// holding register and a queue slot to the sequencer; its first result is then registered
// a byte result holds the output register for two nibbles, high then low, so the
// output port sets the sustained rate; a four-entry queue absorbs the difference
// reset is synchronous; frame buffers read as zero through per-cell written flags,
// so no clearing pass is needed and requests are taken straight after reset
`timescale 1ns / 1ps
`include "assert_macros.svh"

module char_lcd_refresh_overlay_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  clro_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output clro_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  logic [7:0]           pace_gap_r;
  logic [7:0]           tps_r;
  logic                 q_full;
  logic                 push_valid;
  clro_pkg::cmd_t       push_cmd;
  logic                 pop;
  logic                 head_vld;
  clro_pkg::cmd_t       head_cmd;
  clro_pkg::seq_state_t seq_state;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pace_gap_r <= clro_pkg::PACE_GAP_RESET;
      tps_r      <= clro_pkg::TPS_RESET;
    end else if (cfg_we) begin
      unique case (clro_pkg::cfg_reg_t'(cfg_index))
        clro_pkg::REG_PACE_GAP:  pace_gap_r <= cfg_wdata;
        clro_pkg::REG_TICKS_SEC: tps_r      <= cfg_wdata;
        default:                 pace_gap_r <= pace_gap_r;
      endcase
    end
  end

  // front end
  clro_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .ticks_per_sec (tps_r),
    .q_full        (q_full),
    .push_valid    (push_valid),
    .push_cmd      (push_cmd)
  );

  // request queue
  clro_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_vld   (head_vld),
    .head_cmd   (head_cmd)
  );

  // sequencer, buffers and result stage
  clro_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pace_gap  (pace_gap_r),
    .head_vld  (head_vld),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .seq_state (seq_state)
  );

  // checks
  `ASSERT_ALWAYS(a_seq_onehot, $onehot(seq_state))
  `ASSERT_IMPLY(a_done_on_data_low, out_valid && out_data.frame_done, out_data.last_nibble && out_data.reg_select && !out_data.is_read)
  `ASSERT_IMPLY_NEXT(a_low_follows_high, out_valid && !out_stall && !out_data.is_read && !out_data.last_nibble, out_valid && out_data.last_nibble)

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the lcd background refresh block with overlay buffer
// depends on clro_pkg and char_lcd_refresh_overlay_top; predicts every nibble and read
`timescale 1ns / 1ps

module testbench;

  localparam clro_pkg::out_item_t NO_OUT = '0;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  typedef struct {
    clro_pkg::in_item_t  req;
    int                  n_typed;
    clro_pkg::out_item_t typ [2];
  } dir_row_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  clro_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  clro_pkg::out_item_t out_data;
  logic                cfg_we    = 1'b0;
  logic [0:0]          cfg_index = '0;
  logic [7:0]          cfg_wdata = '0;

  // predicted refresh state
  logic [7:0]                 pace_gap;
  logic [7:0]                 tick_mult;
  clro_pkg::seq_state_t       seq_st;
  logic [clro_pkg::IDX_W-1:0] chr_idx;
  logic [7:0]                 pace_cnt;
  logic [15:0]                ovl_elapsed;
  logic [7:0]                 ovl_window;
  logic [7:0]                 main_buf [clro_pkg::CELL_COUNT];
  logic [7:0]                 ovl_buf  [clro_pkg::CELL_COUNT];
  clro_pkg::out_item_t        step_res [2];
  int                         step_cnt;

  // nibbles and read data still to come out of the block
  clro_pkg::out_item_t lcd_out_q [$];
  int                  errors = 0;

  // sender and receiver pacing
  int burst_left = 0;
  int hold_wanted = 0;
  int hold_taken = 0;
  int rx_hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;

  char_lcd_refresh_overlay_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic clro_pkg::in_item_t req(clro_pkg::action_t a, logic l, logic [3:0] c,
                                             logic [7:0] ch, logic [7:0] t);
    clro_pkg::in_item_t r;
    r.action          = a;
    r.line_select     = l;
    r.column          = c;
    r.char_code       = ch;
    r.timeout_seconds = t;
    return r;
  endfunction

  function automatic clro_pkg::out_item_t nib(logic rs, logic [3:0] n, logic last,
                                              logic done);
    clro_pkg::out_item_t o;
    o             = '0;
    o.reg_select  = rs;
    o.bus_nibble  = n;
    o.last_nibble = last;
    o.frame_done  = done;
    return o;
  endfunction

  function automatic clro_pkg::out_item_t rd_item(logic [7:0] d);
    clro_pkg::out_item_t o;
    o           = '0;
    o.is_read   = 1'b1;
    o.read_data = d;
    return o;
  endfunction

  function automatic void reset_refresh();
    pace_gap    = clro_pkg::PACE_GAP_RESET;
    tick_mult   = clro_pkg::TPS_RESET;
    seq_st      = clro_pkg::S_CMD1;
    chr_idx     = '0;
    pace_cnt    = '0;
    ovl_elapsed = '0;
    ovl_window  = '0;
    for (int i = 0; i < clro_pkg::CELL_COUNT; i++) begin
      main_buf[i] = '0;
      ovl_buf[i]  = '0;
    end
  endfunction

  // a byte leaves as high nibble then low nibble
  function automatic void emit_byte(logic rs, logic [7:0] b, logic done);
    step_res[0] = nib(rs, b[7:4], 1'b0, 1'b0);
    step_res[1] = nib(rs, b[3:0], 1'b1, done);
    step_cnt    = 2;
  endfunction

  function automatic void gap_to(clro_pkg::seq_state_t nxt);
    if (pace_cnt >= pace_gap) seq_st = nxt;
  endfunction

  function automatic void send_char(logic line, clro_pkg::seq_state_t gap_st,
                                    clro_pkg::seq_state_t end_st,
                                    logic last_line, logic use_ovl);
    logic [clro_pkg::CELL_W-1:0] pos;
    logic                        done;
    pos      = {line, chr_idx};
    done     = 1'b0;
    chr_idx  = chr_idx + clro_pkg::IDX_W'(1);
    seq_st   = gap_st;
    pace_cnt = '0;
    // wrap at the end of the line
    if (chr_idx == '0) begin
      seq_st = end_st;
      done   = last_line;
    end
    emit_byte(1'b1, use_ovl ? ovl_buf[pos] : main_buf[pos], done);
  endfunction

  // one request through the refresh model, results left in step_res
  function automatic void refresh_step(clro_pkg::in_item_t r);
    logic        use_ovl;
    logic [15:0] prod;
    step_cnt = 0;
    case (clro_pkg::action_t'(r.action))
      clro_pkg::ACT_TICK: begin
        if (pace_cnt != clro_pkg::PACE_MAX) pace_cnt = pace_cnt + 8'd1;
        if (ovl_elapsed != clro_pkg::ELAPSED_MAX) ovl_elapsed = ovl_elapsed + 16'd1;
        use_ovl = 1'b0;
        // window closes once the elapsed count reaches it
        if (ovl_window != '0) begin
          if (ovl_elapsed >= {8'h00, ovl_window}) ovl_window = '0;
          else use_ovl = 1'b1;
        end
        case (seq_st)
          clro_pkg::S_CMD1: begin
            seq_st   = clro_pkg::S_GAP_CMD1;
            pace_cnt = '0;
            emit_byte(1'b0, clro_pkg::CMD_LINE1, 1'b0);
          end
          clro_pkg::S_GAP_CMD1: gap_to(clro_pkg::S_DATA1);
          clro_pkg::S_DATA1:
            send_char(1'b0, clro_pkg::S_GAP_D1, clro_pkg::S_GAP_END1, 1'b0, use_ovl);
          clro_pkg::S_GAP_D1:   gap_to(clro_pkg::S_DATA1);
          clro_pkg::S_GAP_END1: gap_to(clro_pkg::S_CMD2);
          clro_pkg::S_CMD2: begin
            seq_st   = clro_pkg::S_GAP_CMD2;
            pace_cnt = '0;
            emit_byte(1'b0, clro_pkg::CMD_LINE2, 1'b0);
          end
          clro_pkg::S_GAP_CMD2: gap_to(clro_pkg::S_DATA2);
          clro_pkg::S_DATA2:
            send_char(1'b1, clro_pkg::S_GAP_D2, clro_pkg::S_CMD1, 1'b1, use_ovl);
          clro_pkg::S_GAP_D2:   gap_to(clro_pkg::S_DATA2);
          default:              seq_st = clro_pkg::S_CMD1;
        endcase
      end
      clro_pkg::ACT_WR_MAIN: main_buf[{r.line_select, r.column}] = r.char_code;
      clro_pkg::ACT_WR_OVL: begin
        prod        = r.timeout_seconds * tick_mult;
        ovl_window  = prod[7:0];
        ovl_elapsed = '0;
        ovl_buf[{r.line_select, r.column}] = r.char_code;
      end
      default: begin
        step_res[0] = rd_item(main_buf[{1'b1, r.column}]);
        step_cnt    = 1;
      end
    endcase
  endfunction

  function automatic clro_pkg::in_item_t random_request(int tick_pct, int ovl_pct);
    clro_pkg::in_item_t r;
    int                 pick;
    pick              = $urandom_range(0, 99);
    r.line_select     = 1'($urandom_range(0, 1));
    r.column          = 4'($urandom_range(0, 15));
    r.char_code       = 8'($urandom_range(0, 255));
    // short timeouts now and then so windows really expire
    r.timeout_seconds = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 4))
                                                    : 8'($urandom_range(0, 255));
    if (pick < tick_pct) r.action = clro_pkg::ACT_TICK;
    else if (pick < tick_pct + ovl_pct) r.action = clro_pkg::ACT_WR_OVL;
    else if (pick < tick_pct + ovl_pct + (100 - tick_pct - ovl_pct) / 2)
      r.action = clro_pkg::ACT_WR_MAIN;
    else r.action = clro_pkg::ACT_RD_MAIN;
    return r;
  endfunction

  // offer one request, predict it once taken, then maybe leave a gap
  task automatic offer(clro_pkg::in_item_t r, int n_typed, clro_pkg::out_item_t t0,
                       clro_pkg::out_item_t t1);
    int gap;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    refresh_step(r);
    if (n_typed < 0) begin
      for (int i = 0; i < step_cnt; i++) lcd_out_q.push_back(step_res[i]);
    end else begin
      if (n_typed > 0) lcd_out_q.push_back(t0);
      if (n_typed > 1) lcd_out_q.push_back(t1);
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // sender idle until every expected result is out, plus the pipeline latency
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (lcd_out_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [7:0] gap, logic [7:0] mult);
    cfg_we    <= 1'b1;
    cfg_index <= clro_pkg::REG_PACE_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_index <= clro_pkg::REG_TICKS_SEC;
    cfg_wdata <= mult;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pace_gap  = gap;
    tick_mult = mult;
  endtask

  task automatic run_phase(logic [7:0] gap, logic [7:0] mult, int n, int tick_pct,
                           int ovl_pct, bit squeeze, bit pause);
    settle();
    write_config(gap, mult);
    for (int i = 0; i < n; i++) begin
      // receiver holds off while requests keep coming
      if (squeeze && i == 30) hold_wanted <= hold_wanted + 1;
      // sender waits for the block to drain completely
      if (pause && i == n / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (lcd_out_q.size() != 0);
      end
      offer(random_request(tick_pct, ovl_pct), -1, NO_OUT, NO_OUT);
    end
  endtask

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // receiver: result check and stall pattern
  always @(posedge clk) begin
    clro_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lcd_out_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing got %h", $time, out_data);
        errors++;
      end else begin
        want = lcd_out_q.pop_front();
        check_field("is_read", want.is_read, out_data.is_read);
        check_field("reg_select", want.reg_select, out_data.reg_select);
        check_field("bus_nibble", want.bus_nibble, out_data.bus_nibble);
        check_field("last_nibble", want.last_nibble, out_data.last_nibble);
        check_field("frame_done", want.frame_done, out_data.frame_done);
        check_field("read_data", want.read_data, out_data.read_data);
      end
    end
    if (hold_taken != hold_wanted) begin
      hold_taken   = hold_wanted;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_mode_left == 0) begin
      rx_mode_left = $urandom_range(16, 80);
      rx_mode      = $urandom_range(0, 2);
    end else begin
      rx_mode_left--;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // stimulus
  initial begin
    dir_row_t dir_rows [23];
    dir_rows = '{
      // first tick after reset sends the line-one address
      '{req(clro_pkg::ACT_TICK, 1'b0, 4'd0, 8'h00, 8'h00), 2,
        '{nib(1'b0, 4'h8, 1'b0, 1'b0), nib(1'b0, 4'h0, 1'b1, 1'b0)}},
      '{req(clro_pkg::ACT_RD_MAIN, 1'b0, 4'd15, 8'h00, 8'h00), 1,
        '{rd_item(8'h00), NO_OUT}},
      '{req(clro_pkg::ACT_WR_MAIN, 1'b1, 4'd15, 8'hFF, 8'hFF), 0, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_RD_MAIN, 1'b0, 4'd15, 8'hFF, 8'hFF), 1,
        '{rd_item(8'hFF), NO_OUT}},
      '{req(clro_pkg::ACT_WR_MAIN, 1'b0, 4'd0, 8'h3C, 8'h00), -1, '{NO_OUT, NO_OUT}},
      // overlay window set to twelve ticks
      '{req(clro_pkg::ACT_WR_OVL, 1'b0, 4'd0, 8'hC3, 8'h01), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_TICK, 1'b0, 4'd0, 8'h00, 8'h00), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_TICK, 1'b0, 4'd0, 8'h00, 8'h00), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_TICK, 1'b0, 4'd0, 8'h00, 8'h00), -1, '{NO_OUT, NO_OUT}},
      // zero timeout leaves the overlay closed
      '{req(clro_pkg::ACT_WR_OVL, 1'b0, 4'd1, 8'h7E, 8'h00), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_TICK, 1'b1, 4'd15, 8'hFF, 8'hFF), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_TICK, 1'b0, 4'd0, 8'h00, 8'h00), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_TICK, 1'b0, 4'd0, 8'h00, 8'h00), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_WR_MAIN, 1'b1, 4'd0, 8'h00, 8'h00), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_RD_MAIN, 1'b1, 4'd0, 8'hFF, 8'h00), -1, '{NO_OUT, NO_OUT}},
      // largest timeout wraps the window
      '{req(clro_pkg::ACT_WR_OVL, 1'b0, 4'd2, 8'h81, 8'hFF), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_WR_MAIN, 1'b0, 4'd2, 8'hFF, 8'h00), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_TICK, 1'b0, 4'd0, 8'h00, 8'h00), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_TICK, 1'b0, 4'd0, 8'h00, 8'h00), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_TICK, 1'b0, 4'd0, 8'h00, 8'h00), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_WR_MAIN, 1'b1, 4'd8, 8'h5A, 8'h00), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_RD_MAIN, 1'b0, 4'd8, 8'h00, 8'hFF), -1, '{NO_OUT, NO_OUT}},
      '{req(clro_pkg::ACT_TICK, 1'b0, 4'd0, 8'h00, 8'h00), -1, '{NO_OUT, NO_OUT}}
    };

    reset_refresh();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests at the reset settings
    foreach (dir_rows[i])
      offer(dir_rows[i].req, dir_rows[i].n_typed, dir_rows[i].typ[0], dir_rows[i].typ[1]);

    // random phases across the register extremes
    run_phase(8'd0, 8'd1, 180, 60, 4, 1'b1, 1'b0);
    run_phase(8'd255, 8'd255, 320, 90, 2, 1'b0, 1'b1);
    run_phase(8'd1, 8'd255, 150, 60, 12, 1'b0, 1'b0);
    run_phase(8'($urandom_range(0, 6)), 8'($urandom_range(1, 255)), 120, 60, 8, 1'b1, 1'b1);
    run_phase(clro_pkg::PACE_GAP_RESET, clro_pkg::TPS_RESET, 80, 60, 6, 1'b0, 1'b0);

    settle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/clro_pkg.sv
rtl/core/clro_front.sv
rtl/core/clro_queue.sv
rtl/core/clro_back.sv
rtl/core/char_lcd_refresh_overlay_top.sv
tb/testbench.sv
